/* rtl/fba_pkg.sv */
// shared constants, types and codes for the fixed block allocator
package fba_pkg;

    localparam int MAX_BLOCKS   = 256;
    localparam int INDEX_W      = 8;
    localparam int LINK_ADDR_W  = $clog2(MAX_BLOCKS);
    localparam int HEAD_W       = LINK_ADDR_W + 1;
    localparam int BSIZE_W      = 13;
    localparam int CAP_W        = 9;
    localparam int OFFSET_W     = 20;
    localparam int REQ_W        = 2;
    localparam int CFG_IDX_W    = 2;
    localparam int CFG_DATA_W   = 13;
    localparam int POOL_LIMIT   = (MAX_BLOCKS < 256) ? MAX_BLOCKS : 256;

    localparam logic [BSIZE_W-1:0] BSIZE_RST = BSIZE_W'(64);
    localparam logic [CAP_W-1:0]   CAP_RST   = CAP_W'(256);
    localparam logic [HEAD_W-1:0]  HEAD_EMPTY = HEAD_W'(MAX_BLOCKS);

    // request codes
    localparam logic [REQ_W-1:0] REQ_ALLOC = 2'd0;
    localparam logic [REQ_W-1:0] REQ_FREE  = 2'd1;
    localparam logic [REQ_W-1:0] REQ_RESET = 2'd2;

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_BLK_BYTES = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_CAPACITY  = 2'd1;

    typedef logic [HEAD_W-1:0] t_head;

    // decided result handed to the offset stage
    typedef struct packed {
        logic               valid;
        logic [INDEX_W-1:0] index;
        logic               status;
    } t_result;

endpackage

/* rtl/fba_link_ram.sv */
// single write, single read port link memory with registered read data
module fba_link_ram #(
    parameter int DEPTH = 256,
    parameter int WIDTH = 9
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

/* rtl/fba_offset.sv */
// result register stage: forms the byte offset and drives the result strobe
module fba_offset (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  fba_pkg::t_result            i_res,
    input  logic [fba_pkg::BSIZE_W-1:0] i_blk_bytes,
    output logic                        o_strobe,
    output logic [fba_pkg::INDEX_W-1:0] o_block_index,
    output logic [fba_pkg::OFFSET_W-1:0] o_block_offset,
    output logic                        o_status
);
    import fba_pkg::*;

    localparam int PROD_W = INDEX_W + BSIZE_W;

    logic                r_strobe;
    logic [INDEX_W-1:0]  r_index;
    logic [OFFSET_W-1:0] r_offset;
    logic                r_status;
    logic [PROD_W-1:0]   n_prod;

    assign n_prod = PROD_W'(i_res.index) * PROD_W'(i_blk_bytes);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_strobe <= 1'b0;
        end else begin
            r_strobe <= i_res.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_res.valid) begin
            r_index  <= i_res.index;
            r_offset <= n_prod[OFFSET_W-1:0];
            r_status <= i_res.status;
        end
    end

    assign o_strobe       = r_strobe;
    assign o_block_index  = r_index;
    assign o_block_offset = r_offset;
    assign o_status       = r_status;

endmodule

/* rtl/fixed_block_allocator_top.sv */
// fixed block allocator: free list head, bump counter and link memory control
// a transaction accepted in ST_IDLE is decided in ST_EXEC and its result is registered
//   in the offset stage, which drives o_strobe; one result per request
// a new request is taken only in ST_IDLE, since a pop needs the link memory read
//   before the new head is known; busy is high while in ST_EXEC
// the receiver cannot stall; results are strobed for exactly one cycle
// reset (i_rst_n low, synchronous): empty free list, bump count zero,
//   block bytes 64, capacity 256; link memory contents are not cleared
module fixed_block_allocator_top (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           start,
    output logic                           busy,
    input  logic [fba_pkg::REQ_W-1:0]      i_req_type,
    input  logic [fba_pkg::INDEX_W-1:0]    i_free_index,
    output logic                           o_strobe,
    output logic [fba_pkg::INDEX_W-1:0]    o_block_index,
    output logic [fba_pkg::OFFSET_W-1:0]   o_block_offset,
    output logic                           o_status,
    input  logic                           i_cfg_valid,
    output logic                           o_cfg_ready,
    input  logic [fba_pkg::CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [fba_pkg::CFG_DATA_W-1:0] i_cfg_data
);
    import fba_pkg::*;

    localparam logic ST_IDLE = 1'b0;
    localparam logic ST_EXEC = 1'b1;

    logic               r_state;
    logic               n_state;
    t_head              r_head;
    t_head              n_head;
    logic [CAP_W-1:0]   r_bump;
    logic [CAP_W-1:0]   n_bump;
    logic [REQ_W-1:0]   r_req;
    logic [INDEX_W-1:0] r_fidx;
    logic [BSIZE_W-1:0] r_blk_bytes;
    logic [CAP_W-1:0]   r_capacity;
    logic [CAP_W-1:0]   usable;
    logic               accept;
    logic               cfg_we;
    logic               link_we;
    t_head              link_rdata;
    t_result            res;

    assign accept      = start && (r_state == ST_IDLE);
    assign busy        = (r_state == ST_EXEC);
    assign o_cfg_ready = 1'b1;
    assign cfg_we      = i_cfg_valid && o_cfg_ready;

    assign usable = (r_capacity > CAP_W'(POOL_LIMIT)) ? CAP_W'(POOL_LIMIT) : r_capacity;

    fba_link_ram #(
        .DEPTH (MAX_BLOCKS),
        .WIDTH (HEAD_W)
    ) u_link_ram (
        .i_clk   (i_clk),
        .i_we    (link_we),
        .i_waddr (r_fidx[LINK_ADDR_W-1:0]),
        .i_wdata (r_head),
        .i_re    (accept),
        .i_raddr (r_head[LINK_ADDR_W-1:0]),
        .o_rdata (link_rdata)
    );

    // decide the request in the cycle after it is taken, link word now readable
    always_comb begin
        n_state    = r_state;
        n_head     = r_head;
        n_bump     = r_bump;
        link_we    = 1'b0;
        res.valid  = 1'b0;
        res.index  = '0;
        res.status = 1'b0;
        case (r_state)
            ST_IDLE: begin
                if (accept) begin
                    n_state = ST_EXEC;
                end
            end
            ST_EXEC: begin
                n_state   = ST_IDLE;
                res.valid = 1'b1;
                case (r_req)
                    REQ_ALLOC: begin
                        if (r_head < HEAD_EMPTY) begin
                            res.index = r_head[INDEX_W-1:0];
                            n_head    = (link_rdata > HEAD_EMPTY) ? HEAD_EMPTY : link_rdata;
                        end else if (r_bump < usable) begin
                            res.index = r_bump[INDEX_W-1:0];
                            n_bump    = r_bump + CAP_W'(1);
                        end else begin
                            res.status = 1'b1;
                        end
                    end
                    REQ_FREE: begin
                        res.index = r_fidx;
                        if (HEAD_W'(r_fidx) < HEAD_EMPTY) begin
                            link_we = 1'b1;
                            n_head  = HEAD_W'(r_fidx);
                        end
                    end
                    REQ_RESET: begin
                        n_head = HEAD_EMPTY;
                        n_bump = '0;
                    end
                    default: begin
                    end
                endcase
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_head      <= HEAD_EMPTY;
            r_bump      <= '0;
            r_blk_bytes <= BSIZE_RST;
            r_capacity  <= CAP_RST;
        end else begin
            r_state <= n_state;
            r_head  <= n_head;
            r_bump  <= n_bump;
            if (cfg_we) begin
                case (i_cfg_index)
                    CFG_BLK_BYTES: r_blk_bytes <= i_cfg_data[BSIZE_W-1:0];
                    CFG_CAPACITY:  r_capacity  <= i_cfg_data[CAP_W-1:0];
                    default: begin
                    end
                endcase
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_req  <= i_req_type;
            r_fidx <= i_free_index;
        end
    end

    fba_offset u_offset (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_res          (res),
        .i_blk_bytes    (r_blk_bytes),
        .o_strobe       (o_strobe),
        .o_block_index  (o_block_index),
        .o_block_offset (o_block_offset),
        .o_status       (o_status)
    );

endmodule

/* rtl/fba_checker.sv */
// port level checks for the fixed block allocator, bound to the top level
module fba_checker (
    input logic                         i_clk,
    input logic                         i_rst_n,
    input logic                         start,
    input logic                         busy,
    input logic                         o_strobe,
    input logic [fba_pkg::INDEX_W-1:0]  o_block_index,
    input logic [fba_pkg::OFFSET_W-1:0] o_block_offset,
    input logic                         o_status
);

    // a taken transaction makes the block busy for the next cycle
    a_accept_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        start && !busy |=> busy)
        else $error("busy not raised after accepted transaction");

    // the busy cycle always ends in exactly one result and frees the block
    a_busy_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        busy |=> o_strobe && !busy)
        else $error("busy cycle not followed by a result");

    // no result appears without a busy cycle before it
    a_no_spurious: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_strobe |-> $past(busy))
        else $error("result strobe without a request");

    // a failed allocation carries no block
    a_fail_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_strobe && o_status |-> o_block_index == '0 && o_block_offset == '0)
        else $error("exhausted result carries a block");

endmodule

bind fixed_block_allocator_top fba_checker u_fba_checker (
    .i_clk          (i_clk),
    .i_rst_n        (i_rst_n),
    .start          (start),
    .busy           (busy),
    .o_strobe       (o_strobe),
    .o_block_index  (o_block_index),
    .o_block_offset (o_block_offset),
    .o_status       (o_status)
);
